FILE: rtl/hdlc_bit_stuffing_tx_framer_defines.svh
// ----------------------------------------------------------------------------
// HDLC transmit framer assertion macros
// Shared assertion helpers, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef HDLC_BIT_STUFFING_TX_FRAMER_DEFINES_SVH
`define HDLC_BIT_STUFFING_TX_FRAMER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define HBS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define HBS_ASSERT_NEVER(label, expr, msg) \
    `HBS_ASSERT(label, !(expr), msg)
`else
`define HBS_ASSERT(label, prop, msg)
`define HBS_ASSERT_NEVER(label, expr, msg)
`endif

`endif

FILE: rtl/hbs_pkg.sv
// ----------------------------------------------------------------------------
// HDLC transmit framer package
// Beat types, operation and register codes, reset values and the CRC step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hbs_pkg;

    localparam int LIMIT_W = 13;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int QDEPTH = 2;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_FLAG  = 2'd1;
    localparam logic [1:0] OP_DATA  = 2'd2;
    localparam logic [1:0] OP_END   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_POLY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLAG  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 2'd3;

    localparam logic [15:0] RST_POLY  = 16'h8408;
    localparam logic [15:0] RST_START = 16'hFFFF;
    localparam logic [7:0]  RST_FLAG  = 8'h7E;
    localparam logic [LIMIT_W-1:0] RST_LIMIT = 13'd4096;

    localparam logic [2:0] STUFF_RUN = 3'd5;
    localparam logic [2:0] RUN_MAX   = 3'd7;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic line_bit;
        logic last_in_run;
        logic frame_done;
    } sym_t;

    typedef struct packed {
        logic [15:0]        crc_polynomial;
        logic [15:0]        crc_start_value;
        logic [7:0]         flag_pattern;
        logic [LIMIT_W-1:0] bit_limit;
    } cfg_t;

    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic b,
                                             input logic [15:0] poly);
        logic [15:0] c;
        c = crc ^ {15'd0, b};
        crc_step = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
    endfunction

endpackage

FILE: rtl/hdlc_bit_stuffing_tx_framer.sv
// ----------------------------------------------------------------------------
// HDLC transmit framer with CRC-16 and bit stuffing
// Turns start, flag, data and end operations into a serial line bit stream.
// ----------------------------------------------------------------------------
// Each operation beat waits in a two-entry queue and is then loaded into the
// serializer, which sends one line bit per cycle while the output is not
// stalled. A start sends no bits, a flag sends its pattern, a data byte sends
// its bits plus one stuffed zero after each run of five ones, and an end sends
// the two FCS bytes, stuffed, then a flag. Bits beyond the frame bit limit are
// dropped; an item that sends no bits produces no beat.
`timescale 1ns / 1ps

module hdlc_bit_stuffing_tx_framer #(
    parameter int MAX_FRAME_BYTES = 512
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_ready,
    input  hbs_pkg::item_t                     item_data,
    output logic                              sym_valid,
    input  logic                              sym_ready,
    output hbs_pkg::sym_t                      sym_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [hbs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [hbs_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import hbs_pkg::*;

    localparam logic [31:0] CAP_BITS = 32'(MAX_FRAME_BYTES) * 32'd8;

    logic [15:0]        poly_reg;
    logic [15:0]        start_reg;
    logic [7:0]         flag_reg;
    logic [LIMIT_W-1:0] limit_reg;
    cfg_t               cfg;
    logic               q_valid;
    logic               q_pop;
    item_t              q_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_reg <= RST_POLY;
            start_reg <= RST_START;
            flag_reg <= RST_FLAG;
            limit_reg <= RST_LIMIT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_POLY:  poly_reg <= cfg_data;
                CFG_START: start_reg <= cfg_data;
                CFG_FLAG:  flag_reg <= cfg_data[7:0];
                CFG_LIMIT: limit_reg <= cfg_data[LIMIT_W-1:0];
                default:   poly_reg <= poly_reg;
            endcase
        end
    end

    always_comb
    begin
        cfg.crc_polynomial = poly_reg;
        cfg.crc_start_value = start_reg;
        cfg.flag_pattern = flag_reg;
        cfg.bit_limit = ({{(32 - LIMIT_W){1'b0}}, limit_reg} < CAP_BITS) ?
                        limit_reg : CAP_BITS[LIMIT_W-1:0];
    end

    hbs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item_data  (item_data),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_item     (q_item)
    );

    hbs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .sym_valid (sym_valid),
        .sym_ready (sym_ready),
        .sym_data  (sym_data)
    );

endmodule

FILE: rtl/hbs_front.sv
// ----------------------------------------------------------------------------
// HDLC transmit framer front end
// Accepts operation beats and holds them in a short queue for the serializer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "hdlc_bit_stuffing_tx_framer_defines.svh"

module hbs_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    output logic          item_ready,
    input  hbs_pkg::item_t item_data,
    output logic          q_valid,
    input  logic          q_pop,
    output hbs_pkg::item_t q_item
);
    import hbs_pkg::*;

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W = $clog2(QDEPTH + 1);

    item_t             mem_reg [QDEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              push;
    logic              pop;

    assign item_ready = (count_reg != CNT_W'(QDEPTH));
    assign push = item_valid && item_ready;
    assign pop = q_pop && q_valid;
    assign q_valid = (count_reg != '0);
    assign q_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= item_data;
        end
    end

    `HBS_ASSERT(a_count_bound, count_reg <= CNT_W'(QDEPTH), "queue count past its depth")
    `HBS_ASSERT(a_pop_nonempty, q_pop |-> q_valid, "queue popped while empty")

endmodule

FILE: rtl/hbs_back.sv
// ----------------------------------------------------------------------------
// HDLC transmit framer serializer
// Sends one line bit per cycle unless stalled; CRC, bit stuffing, bit limit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "hdlc_bit_stuffing_tx_framer_defines.svh"

module hbs_back (
    input  logic          clk,
    input  logic          rst_n,
    input  hbs_pkg::cfg_t  cfg,
    input  logic          q_valid,
    input  hbs_pkg::item_t q_item,
    output logic          q_pop,
    output logic          sym_valid,
    input  logic          sym_ready,
    output hbs_pkg::sym_t  sym_data
);
    import hbs_pkg::*;

    localparam logic [1:0] PH_BYTE0 = 2'd0;
    localparam logic [1:0] PH_BYTE1 = 2'd1;
    localparam logic [1:0] PH_FLAG  = 2'd2;

    logic               busy_reg, busy_next;
    logic [1:0]         op_reg, op_next;
    logic [1:0]         phase_reg, phase_next;
    logic [2:0]         idx_reg, idx_next;
    logic               stuff_reg, stuff_next;
    logic [7:0]         byte_reg, byte_next;
    logic [7:0]         fcs_hi_reg, fcs_hi_next;
    logic [15:0]        crc_reg, crc_next;
    logic [2:0]         ones_reg, ones_next;
    logic [LIMIT_W-1:0] bits_reg, bits_next;
    logic               sym_valid_reg;
    sym_t               sym_data_reg;

    logic               emit;
    logic               emit_bit;
    logic               emit_last;
    logic               byte_end;
    logic               full;
    logic               full_after;
    logic               more_bytes;
    logic               cur_bit;
    logic [2:0]         ones_inc;
    logic               out_space;
    logic               step_en;

    assign full = (bits_reg >= cfg.bit_limit);
    assign full_after = (({1'b0, bits_reg} + (LIMIT_W + 1)'(1)) >= {1'b0, cfg.bit_limit});
    assign more_bytes = (op_reg == OP_END);
    assign cur_bit = byte_reg[idx_reg];
    assign ones_inc = (ones_reg == RUN_MAX) ? RUN_MAX : ones_reg + 3'd1;
    assign out_space = !sym_valid_reg || sym_ready;
    assign step_en = !emit || out_space;

    always_comb
    begin
        busy_next = busy_reg;
        op_next = op_reg;
        phase_next = phase_reg;
        idx_next = idx_reg;
        stuff_next = stuff_reg;
        byte_next = byte_reg;
        fcs_hi_next = fcs_hi_reg;
        crc_next = crc_reg;
        ones_next = ones_reg;
        bits_next = bits_reg;
        emit = 1'b0;
        emit_bit = 1'b0;
        emit_last = 1'b0;
        byte_end = 1'b0;
        q_pop = 1'b0;
        if (!busy_reg)
        begin
            if (q_valid)
            begin
                q_pop = 1'b1;
                busy_next = 1'b1;
                op_next = q_item.operation;
                phase_next = (q_item.operation == OP_FLAG) ? PH_FLAG : PH_BYTE0;
                idx_next = 3'd0;
                stuff_next = 1'b0;
                byte_next = (q_item.operation == OP_END) ? ~crc_reg[7:0] : q_item.data_byte;
                fcs_hi_next = ~crc_reg[15:8];
            end
        end
        else if (op_reg == OP_START)
        begin
            crc_next = cfg.crc_start_value;
            ones_next = 3'd0;
            bits_next = '0;
            busy_next = 1'b0;
        end
        else if (phase_reg == PH_FLAG)
        begin
            if (full)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                emit = 1'b1;
                emit_bit = cfg.flag_pattern[idx_reg];
                emit_last = full_after || (idx_reg == 3'd7);
                if (idx_reg == 3'd7)
                begin
                    busy_next = 1'b0;
                end
                else
                begin
                    idx_next = idx_reg + 3'd1;
                end
            end
        end
        else if (stuff_reg)
        begin
            if (full)
            begin
                byte_end = 1'b1;
            end
            else
            begin
                emit = 1'b1;
                emit_bit = 1'b0;
                emit_last = full_after || ((idx_reg == 3'd7) && !more_bytes);
                ones_next = 3'd0;
                stuff_next = 1'b0;
                if (idx_reg == 3'd7)
                begin
                    byte_end = 1'b1;
                end
                else
                begin
                    idx_next = idx_reg + 3'd1;
                end
            end
        end
        else
        begin
            crc_next = crc_step(crc_reg, cur_bit, cfg.crc_polynomial);
            if (full)
            begin
                byte_end = 1'b1;
            end
            else
            begin
                emit = 1'b1;
                emit_bit = cur_bit;
                if (cur_bit && (ones_inc >= STUFF_RUN))
                begin
                    ones_next = ones_inc;
                    stuff_next = 1'b1;
                    emit_last = full_after;
                end
                else
                begin
                    ones_next = cur_bit ? ones_inc : 3'd0;
                    emit_last = full_after || ((idx_reg == 3'd7) && !more_bytes);
                    if (idx_reg == 3'd7)
                    begin
                        byte_end = 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end
        end

        if (byte_end)
        begin
            stuff_next = 1'b0;
            idx_next = 3'd0;
            if (op_reg == OP_DATA)
            begin
                busy_next = 1'b0;
            end
            else if (phase_reg == PH_BYTE0)
            begin
                phase_next = PH_BYTE1;
                byte_next = fcs_hi_reg;
            end
            else
            begin
                phase_next = PH_FLAG;
            end
        end

        if (emit)
        begin
            bits_next = bits_reg + LIMIT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            op_reg <= OP_START;
            phase_reg <= PH_BYTE0;
            idx_reg <= 3'd0;
            stuff_reg <= 1'b0;
            crc_reg <= 16'hFFFF;
            ones_reg <= 3'd0;
            bits_reg <= '0;
            sym_valid_reg <= 1'b0;
        end
        else
        begin
            if (step_en)
            begin
                busy_reg <= busy_next;
                op_reg <= op_next;
                phase_reg <= phase_next;
                idx_reg <= idx_next;
                stuff_reg <= stuff_next;
                crc_reg <= crc_next;
                ones_reg <= ones_next;
                bits_reg <= bits_next;
            end
            if (step_en && emit)
            begin
                sym_valid_reg <= 1'b1;
            end
            else if (sym_ready)
            begin
                sym_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            byte_reg <= byte_next;
            fcs_hi_reg <= fcs_hi_next;
        end
        if (step_en && emit)
        begin
            sym_data_reg.line_bit <= emit_bit;
            sym_data_reg.last_in_run <= emit_last;
            sym_data_reg.frame_done <= emit_last && (op_reg == OP_END);
        end
    end

    assign sym_valid = sym_valid_reg;
    assign sym_data = sym_data_reg;

    `HBS_ASSERT(a_stuff_after_run, stuff_reg |-> busy_reg && ones_reg >= STUFF_RUN, "stray stuff")
    `HBS_ASSERT_NEVER(a_flag_unstuffed, stuff_reg && phase_reg == PH_FLAG, "stuff during a flag")
    `HBS_ASSERT(a_no_load_when_busy, q_pop |-> !busy_reg, "queue popped while an item is in progress")

endmodule

FILE: bench/tb_hdlc_bit_stuffing_tx_framer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the HDLC transmit framer
// Drives start, flag, data and end operations under several register
// settings, with random stalls on both channels, and checks every line bit
// beat against a bit-serial model of stuffing, CRC and the frame bit limit.
// ----------------------------------------------------------------------------

module tb_hdlc_bit_stuffing_tx_framer;

    import hbs_pkg::*;

    localparam int MAX_FRAME_BYTES = 512;
    localparam int FRAME_CAP = MAX_FRAME_BYTES * 8;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASES = 6;
    localparam int PHASE_ITEMS = 50;
    localparam int TIMEOUT_NS = 5_000_000;
    localparam int NDIR = 37;

    typedef struct packed {
        logic                 is_reg;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [15:0]          reg_val;
        logic [1:0]           op;
        logic [7:0]           data;
        logic                 typed;
        logic [4:0]           n_bits;
        logic [27:0]          bits;
    } step_t;

    localparam step_t DIRECTED [NDIR] = '{
        '{1'b0, CFG_POLY,  16'h0000, OP_START, 8'h00, 1'b1, 5'd0, 28'h0000000},
        '{1'b0, CFG_POLY,  16'h0000, OP_FLAG,  8'h00, 1'b1, 5'd8, 28'h000007E},
        '{1'b0, CFG_POLY,  16'h0000, OP_DATA,  8'h00, 1'b1, 5'd8, 28'h0000000},
        '{1'b0, CFG_POLY,  16'h0000, OP_DATA,  8'hFF, 1'b1, 5'd9, 28'h00001DF},
        '{1'b0, CFG_POLY,  16'h0000, OP_DATA,  8'hFF, 1'b0, 5'd0, 28'h0000000},
        '{1'b0, CFG_POLY,  16'h0000, OP_DATA,  8'h80, 1'b0, 5'd0, 28'h0000000},
        '{1'b0, CFG_POLY,  16'h0000, OP_DATA,  8'hA5, 1'b0, 5'd0, 28'h0000000},
        '{1'b0, CFG_POLY,  16'h0000, OP_END,   8'h00, 1'b0, 5'd0, 28'h0000000},
        '{1'b1, CFG_LIMIT, 16'd5,    OP_START, 8'h00, 1'b0, 5'd0, 28'h0000000},
        '{1'b0, CFG_POLY,  16'h0000, OP_START, 8'h00, 1'b1, 5'd0, 28'h0000000},
        '{1'b0, CFG_POLY,  16'h0000, OP_FLAG,  8'h00, 1'b1, 5'd5, 28'h000001E},
        '{1'b0, CFG_POLY,  16'h0000, OP_DATA,  8'hFF, 1'b1, 5'd0, 28'h0000000},
        '{1'b0, CFG_POLY,  16'h0000, OP_END,   8'h00, 1'b1, 5'd0, 28'h0000000},
        '{1'b0, CFG_POLY,  16'h0000, OP_START, 8'h00, 1'b1, 5'd0, 28'h0000000},
        '{1'b0, CFG_POLY,  16'h0000, OP_DATA,  8'hFF, 1'b1, 5'd5, 28'h000001F},
        '{1'b1, CFG_LIMIT, 16'd4096, OP_START, 8'h00, 1'b0, 5'd0, 28'h0000000},
        '{1'b0, CFG_POLY,  16'h0000, OP_DATA,  8'h01, 1'b0, 5'd0, 28'h0000000},
        '{1'b0, CFG_POLY,  16'h0000, OP_END,   8'h00, 1'b0, 5'd0, 28'h0000000},
        '{1'b1, CFG_LIMIT, 16'd0,    OP_START, 8'h00, 1'b0, 5'd0, 28'h0000000},
        '{1'b0, CFG_POLY,  16'h0000, OP_START, 8'h00, 1'b1, 5'd0, 28'h0000000},
        '{1'b0, CFG_POLY,  16'h0000, OP_FLAG,  8'h00, 1'b1, 5'd0, 28'h0000000},
        '{1'b1, CFG_POLY,  16'hFFFF, OP_START, 8'h00, 1'b0, 5'd0, 28'h0000000},
        '{1'b1, CFG_START, 16'h0000, OP_START, 8'h00, 1'b0, 5'd0, 28'h0000000},
        '{1'b1, CFG_FLAG,  16'h00FF, OP_START, 8'h00, 1'b0, 5'd0, 28'h0000000},
        '{1'b1, CFG_LIMIT, 16'd12,   OP_START, 8'h00, 1'b0, 5'd0, 28'h0000000},
        '{1'b0, CFG_POLY,  16'h0000, OP_START, 8'h00, 1'b1, 5'd0, 28'h0000000},
        '{1'b0, CFG_POLY,  16'h0000, OP_FLAG,  8'h00, 1'b1, 5'd8, 28'h00000FF},
        '{1'b0, CFG_POLY,  16'h0000, OP_DATA,  8'h7F, 1'b0, 5'd0, 28'h0000000},
        '{1'b0, CFG_POLY,  16'h0000, OP_END,   8'h00, 1'b0, 5'd0, 28'h0000000},
        '{1'b1, CFG_POLY,  16'h0000, OP_START, 8'h00, 1'b0, 5'd0, 28'h0000000},
        '{1'b1, CFG_START, 16'hFFFF, OP_START, 8'h00, 1'b0, 5'd0, 28'h0000000},
        '{1'b1, CFG_FLAG,  16'h0000, OP_START, 8'h00, 1'b0, 5'd0, 28'h0000000},
        '{1'b1, CFG_LIMIT, 16'd4096, OP_START, 8'h00, 1'b0, 5'd0, 28'h0000000},
        '{1'b0, CFG_POLY,  16'h0000, OP_START, 8'h00, 1'b1, 5'd0, 28'h0000000},
        '{1'b0, CFG_POLY,  16'h0000, OP_DATA,  8'h3C, 1'b0, 5'd0, 28'h0000000},
        '{1'b0, CFG_POLY,  16'h0000, OP_END,   8'h00, 1'b0, 5'd0, 28'h0000000},
        '{1'b0, CFG_POLY,  16'h0000, OP_FLAG,  8'h00, 1'b1, 5'd8, 28'h0000000}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_ready;
    item_t item_data = '0;
    logic sym_valid;
    logic sym_ready = 1'b0;
    sym_t sym_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    bit calm = 1'b0;
    int fails = 0;
    int items_sent = 0;
    int reg_writes = 0;
    int beats_seen = 0;
    int frames_closed = 0;

    logic [15:0]        cfg_poly = RST_POLY;
    logic [15:0]        cfg_seed = RST_START;
    logic [7:0]         cfg_flag = RST_FLAG;
    logic [LIMIT_W-1:0] cfg_limit = RST_LIMIT;
    logic [15:0]        crc_acc = 16'hFFFF;
    logic [2:0]         ones_seen = '0;
    logic [LIMIT_W-1:0] bits_on_line = '0;

    sym_t op_beats[$];
    sym_t line_due[$];

    hdlc_bit_stuffing_tx_framer #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .item_data(item_data),
        .sym_valid(sym_valid),
        .sym_ready(sym_ready),
        .sym_data(sym_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    function automatic bit frame_is_full();
        int lim;
        lim = (int'(cfg_limit) < FRAME_CAP) ? int'(cfg_limit) : FRAME_CAP;
        return int'(bits_on_line) >= lim;
    endfunction

    function automatic void put_bit(input logic b);
        sym_t s;
        s.line_bit = b;
        s.last_in_run = 1'b0;
        s.frame_done = 1'b0;
        op_beats.push_back(s);
        bits_on_line = bits_on_line + 1'b1;
    endfunction

    function automatic void crc_shift_in(input logic b);
        logic [15:0] c;
        c = crc_acc ^ {15'd0, b};
        crc_acc = c[0] ? ((c >> 1) ^ cfg_poly) : (c >> 1);
    endfunction

    function automatic void stuff_byte(input logic [7:0] v);
        logic b;
        for (int i = 0; i < 8; i++)
        begin
            b = v[i];
            crc_shift_in(b);
            if (b)
            begin
                if (frame_is_full())
                    return;
                put_bit(1'b1);
                if (ones_seen < RUN_MAX)
                    ones_seen = ones_seen + 1'b1;
                if (ones_seen < STUFF_RUN)
                    continue;
            end
            if (frame_is_full())
                return;
            put_bit(1'b0);
            ones_seen = '0;
        end
    endfunction

    function automatic void put_flag();
        for (int i = 0; i < 8; i++)
        begin
            if (frame_is_full())
                return;
            put_bit(cfg_flag[i]);
        end
    endfunction

    function automatic void serialize_op(input item_t it);
        logic [15:0] fcs;
        sym_t tail;
        op_beats.delete();
        case (it.operation)
            OP_START:
            begin
                crc_acc = cfg_seed;
                ones_seen = '0;
                bits_on_line = '0;
            end
            OP_FLAG: put_flag();
            OP_DATA: stuff_byte(it.data_byte);
            default:
            begin
                fcs = crc_acc;
                stuff_byte(~fcs[7:0]);
                stuff_byte(~fcs[15:8]);
                put_flag();
            end
        endcase
        if (op_beats.size() > 0)
        begin
            tail = op_beats.pop_back();
            tail.last_in_run = 1'b1;
            tail.frame_done = (it.operation == OP_END);
            op_beats.push_back(tail);
        end
    endfunction

    task automatic push_op(input logic [1:0] op, input logic [7:0] data, input logic typed,
                           input logic [4:0] n_bits, input logic [27:0] bits);
        int gap;
        item_t it;
        sym_t s;
        it.operation = op;
        it.data_byte = data;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 8);
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_data <= it;
        item_valid <= 1'b1;
        do @(posedge clk); while (!item_ready);
        serialize_op(it);
        if (typed)
        begin
            op_beats.delete();
            for (int k = 0; k < int'(n_bits); k++)
            begin
                s.line_bit = bits[k];
                s.last_in_run = (k == int'(n_bits) - 1);
                s.frame_done = (k == int'(n_bits) - 1) && (op == OP_END);
                op_beats.push_back(s);
            end
        end
        foreach (op_beats[k])
            line_due.push_back(op_beats[k]);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        item_valid <= 1'b0;
        while (line_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_POLY:  cfg_poly = val;
            CFG_START: cfg_seed = val;
            CFG_FLAG:  cfg_flag = val[7:0];
            default:   cfg_limit = val[LIMIT_W-1:0];
        endcase
        reg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        sym_t want;
        if (rst_n && sym_valid && sym_ready)
        begin
            beats_seen++;
            if (sym_data.frame_done)
                frames_closed++;
            if (line_due.size() == 0)
            begin
                $error("line beat arrived with nothing expected");
                fails++;
            end
            else
            begin
                want = line_due.pop_front();
                if (sym_data.line_bit !== want.line_bit)
                begin
                    $error("line_bit mismatch: expected %0b, actual %0b",
                           want.line_bit, sym_data.line_bit);
                    fails++;
                end
                if (sym_data.last_in_run !== want.last_in_run)
                begin
                    $error("last_in_run mismatch: expected %0b, actual %0b",
                           want.last_in_run, sym_data.last_in_run);
                    fails++;
                end
                if (sym_data.frame_done !== want.frame_done)
                begin
                    $error("frame_done mismatch: expected %0b, actual %0b",
                           want.frame_done, sym_data.frame_done);
                    fails++;
                end
            end
        end
    end

    initial
    begin
        int hold;
        int stretch;
        bit choppy;
        stretch = 0;
        choppy = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stretch == 0)
            begin
                stretch = $urandom_range(20, 120);
                choppy = $urandom_range(0, 1);
            end
            stretch--;
            if (!calm && choppy && $urandom_range(0, 3) == 0)
            begin
                hold = $urandom_range(1, 8);
                sym_ready <= 1'b0;
                repeat (hold) @(negedge clk);
            end
            sym_ready <= 1'b1;
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        int phase_end;
        logic [15:0] v;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int r = 0; r < NDIR; r++)
        begin
            if (DIRECTED[r].is_reg)
                write_reg(DIRECTED[r].reg_idx, DIRECTED[r].reg_val);
            else
                push_op(DIRECTED[r].op, DIRECTED[r].data, DIRECTED[r].typed,
                        DIRECTED[r].n_bits, DIRECTED[r].bits);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            calm = (p == PHASES - 1);
            v = ($urandom_range(0, 2) == 0) ? RST_POLY : 16'($urandom);
            write_reg(CFG_POLY, v);
            v = ($urandom_range(0, 2) == 0) ? RST_START : 16'($urandom);
            write_reg(CFG_START, v);
            v = ($urandom_range(0, 1) == 0) ? {8'd0, RST_FLAG} : {8'd0, 8'($urandom)};
            write_reg(CFG_FLAG, v);
            case ($urandom_range(0, 3))
                0, 1: v = {3'd0, RST_LIMIT};
                2: v = 16'($urandom_range(1, FRAME_CAP));
                default: v = 16'($urandom_range(0, 160));
            endcase
            write_reg(CFG_LIMIT, v);

            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end)
            begin
                if ($urandom_range(0, 9) < 8)
                begin
                    push_op(OP_START, 8'($urandom), 1'b0, 5'd0, 28'd0);
                    repeat ($urandom_range(1, 2))
                        push_op(OP_FLAG, 8'($urandom), 1'b0, 5'd0, 28'd0);
                    repeat ($urandom_range(0, 10))
                        push_op(OP_DATA,
                                ($urandom_range(0, 3) == 0) ? 8'hFF :
                                ($urandom_range(0, 1) ? 8'($urandom | $urandom) :
                                 8'($urandom)),
                                1'b0, 5'd0, 28'd0);
                    if ($urandom_range(0, 7) != 0)
                        push_op(OP_END, 8'($urandom), 1'b0, 5'd0, 28'd0);
                    if ($urandom_range(0, 1) == 0)
                        push_op(OP_FLAG, 8'($urandom), 1'b0, 5'd0, 28'd0);
                end
                else
                    push_op(2'($urandom), 8'($urandom), 1'b0, 5'd0, 28'd0);
            end
        end

        item_valid <= 1'b0;
        while (line_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d operations across %0d register writes and checked %0d line beats.",
                 items_sent, reg_writes, beats_seen);
        $display("%0d frames closed with a frame_done beat.", frames_closed);
        if (fails == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/hbs_pkg.sv
rtl/hbs_front.sv
rtl/hbs_back.sv
rtl/hdlc_bit_stuffing_tx_framer.sv
bench/tb_hdlc_bit_stuffing_tx_framer.sv
